/* hdl/arp_pkg.sv */
// Shared types and constants for the AArch64 relocation patch block.
// No dependencies; imported by the channel interfaces and the core.
package arp_pkg;

   localparam int KIND_W = 4;
   localparam int WORD_W = 64;

   // relocation kind codes; codes above KIND_PRELX are unknown
   typedef enum logic [KIND_W-1:0] {
      KIND_PREL16   = 4'd0,
      KIND_PREL32   = 4'd1,
      KIND_PREL64   = 4'd2,
      KIND_ADRLO21  = 4'd3,
      KIND_ABS32    = 4'd4,
      KIND_ABS64    = 4'd5,
      KIND_CONDBR19 = 4'd6,
      KIND_CALL26   = 4'd7,
      KIND_PRELX    = 4'd8
   } kind_type;

   typedef logic [WORD_W-1:0] word_type;

endpackage

/* hdl/arp_ifs.sv */
// Valid/ready channel interfaces for the relocation patch block.
// Depends on arp_pkg for field widths.
interface arp_req_if import arp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] req_type;
   word_type          old_word;
   word_type          target_value;
   word_type          place_address;

   modport source (output valid, output req_type, output old_word,
                   output target_value, output place_address, input ready);
   modport sink   (input valid, input req_type, input old_word,
                   input target_value, input place_address, output ready);
endinterface

interface arp_rsp_if import arp_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type new_word;
   logic     bad_type;

   modport source (output valid, output new_word, output bad_type, input ready);
   modport sink   (input valid, input new_word, input bad_type, output ready);
endinterface

/* hdl/aarch64_relocation_patch_core.sv */
// AArch64 relocation site patcher: input register, patch logic, result register.
// Depends on arp_pkg and the channel interfaces in arp_ifs.sv.
//
//   channel  dir  modport  word contents
//   req_if   in   sink     req_type, old_word, target_value, place_address
//   rsp_if   out  source   new_word, bad_type
//
// Two register stages: one word is accepted every cycle unless a stall on rsp_if
// backs up into them. Each word passes through the capture registers and then the
// result register, which drives rsp_if. The 64-bit place subtract and the addend pick feed
// the capture registers; the patch stage does one 64-bit add and the bit-field
// inserts. Synchronous active-high reset clears only the stage valid flags.
// A stall on rsp_if holds the result register and backs up into the capture
// stage; req_if.ready drops only when both stages are full and rsp_if stalls.
module aarch64_relocation_patch_core import arp_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   arp_req_if.sink   req_if,
   arp_rsp_if.source rsp_if
);

   // capture stage
   logic              s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0] kind_ff;
   word_type          old_ff;
   word_type          disp_ff;     // target - place
   word_type          addend_ff;   // disp for PC-relative kinds, target for absolute

   // result stage
   logic     s2_valid_ff, s2_valid_in;
   word_type new_word_ff, new_word_in;
   logic     bad_ff, bad_in;

   logic     s2_load, s1_load;
   word_type disp_in, addend_in;
   word_type sum;
   logic [18:0] br_field;

   assign s2_load     = s1_valid_ff && (!s2_valid_ff || rsp_if.ready);
   assign s1_load     = req_if.valid && req_if.ready;
   assign req_if.ready = !s1_valid_ff || s2_load;

   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_load);
   assign s2_valid_in = s2_load || (s2_valid_ff && !rsp_if.ready);

   assign disp_in = req_if.target_value - req_if.place_address;

   always_comb begin
      unique case (req_if.req_type) inside
         KIND_ABS32, KIND_ABS64: addend_in = req_if.target_value;
         default:                addend_in = disp_in;
      endcase
   end

   // patch logic
   assign sum      = old_ff + addend_ff;
   assign br_field = old_ff[23:5] + disp_ff[20:2];

   always_comb begin
      bad_in = 1'b0;
      unique case (kind_ff) inside
         KIND_PREL16:             new_word_in = {old_ff[63:16], sum[15:0]};
         KIND_PREL32, KIND_ABS32: new_word_in = {old_ff[63:32], sum[31:0]};
         KIND_PREL64, KIND_ABS64: new_word_in = sum;
         // immlo at 30:29, immhi at 23:5, op bit 31 kept
         KIND_ADRLO21: new_word_in = {old_ff[63:31], disp_ff[1:0], old_ff[28:24],
                                      disp_ff[20:2], old_ff[4:0]};
         KIND_CONDBR19: new_word_in = {old_ff[63:24], br_field, old_ff[4:0]};
         KIND_CALL26:   new_word_in = {old_ff[63:26], disp_ff[27:2]};
         KIND_PRELX:    new_word_in = old_ff;
         default: begin
            new_word_in = old_ff;
            bad_in      = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_load) begin
         kind_ff   <= req_if.req_type;
         old_ff    <= req_if.old_word;
         disp_ff   <= disp_in;
         addend_ff <= addend_in;
      end
      if (s2_load) begin
         new_word_ff <= new_word_in;
         bad_ff      <= bad_in;
      end
   end

   assign rsp_if.valid    = s2_valid_ff;
   assign rsp_if.new_word = new_word_ff;
   assign rsp_if.bad_type = bad_ff;

endmodule
